/* hdl/rpt_pkg.sv */
// Package: shared constants, command codes and controller/datapath structs.
`timescale 1ns / 1ps
`default_nettype none
package rpt_pkg;
    localparam int WinDepth = 256;
    localparam int PtrW     = $clog2(WinDepth);
    localparam int CntW     = $clog2(WinDepth + 1);
    localparam int LimW     = 9;
    localparam int IdxW     = 64;

    localparam logic [3:0] CMD_INIT      = 4'd0;
    localparam logic [3:0] CMD_PROBE     = 4'd1;
    localparam logic [3:0] CMD_REPLICATE = 4'd2;
    localparam logic [3:0] CMD_SNAPSHOT  = 4'd3;
    localparam logic [3:0] CMD_UPDATE    = 4'd4;
    localparam logic [3:0] CMD_OPTIM     = 4'd5;
    localparam logic [3:0] CMD_SNAPFAIL  = 4'd6;
    localparam logic [3:0] CMD_DECR      = 4'd7;
    localparam logic [3:0] CMD_PAUSE     = 4'd8;
    localparam logic [3:0] CMD_RESUME    = 4'd9;
    localparam logic [3:0] CMD_ADD       = 4'd10;
    localparam logic [3:0] CMD_FREETO    = 4'd11;
    localparam logic [3:0] CMD_FREEFIRST = 4'd12;

    localparam logic [1:0] MODE_PROBE     = 2'd0;
    localparam logic [1:0] MODE_REPLICATE = 2'd1;
    localparam logic [1:0] MODE_SNAPSHOT  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic exec;       // apply scalar command / add
        logic rd_head;    // issue ram read at head pointer
        logic set_bound;  // take bound from ram read data
        logic free_step;  // entry at read pointer freed, advance
        logic free_done;  // finalize head/count
        logic out_load;   // capture result
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] cmd;
        logic       empty;
        logic       more;   // entries left to test
        logic       le;     // ram data <= bound
    } t_sts;
endpackage
`default_nettype wire

/* hdl/replication_progress_tracker.sv */
// Top level: replication progress tracker for one peer.
//  channel | dir | handshake          | payload
//  s_axis  | in  | tvalid/tready      | tdata: cmd, index, peer_last_index
//  m_axis  | out | tvalid/tready      | tdata: status and indexes
//  cfg     | in  | i_cfg_we           | i_cfg_wdata: inflight_limit
// A scalar command passes the execute state and then the output state; freeto
// walks the window RAM, one read and one test per entry freed, and freefirst
// first reads the head entry as its bound before the same walk.
// Synchronous active-low reset, no clearing pass.
// A new input is taken once the previous result is in the output register;
// a stalled output holds only the final hand-off.
`timescale 1ns / 1ps
`default_nettype none
module replication_progress_tracker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [3:0] cmd, [67:4] index, [131:68] peer_last_index, zero fill
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] accepted, [1] paused_now, [2] snapshot_abort, [4:3] mode_now,
    // [68:5] match_out, [132:69] next_out, [196:133] pending_out,
    // [205:197] window_fill, [206] overflow_error, zero fill
    output logic [207:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [8:0]   i_cfg_wdata
);
    rpt_pkg::t_ctl ctl;
    rpt_pkg::t_sts sts;
    logic          idle;
    logic [207:0]  out_data;

    assign s_axis_tready = idle;
    assign m_axis_tdata  = out_data;

    rpt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (s_axis_tvalid && idle),
        .i_out_busy(m_axis_tvalid && !m_axis_tready),
        .i_sts     (sts),
        .o_idle    (idle),
        .o_ctl     (ctl)
    );

    rpt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cmd      (s_axis_tdata[3:0]),
        .i_index    (s_axis_tdata[67:4]),
        .i_peer_last(s_axis_tdata[131:68]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (out_data),
        .o_sts      (sts)
    );
endmodule
`default_nettype wire

/* hdl/rpt_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/rpt_ctrl.sv */
// Controller: sequences load, execute, window walk and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module rpt_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_fire,
    input  wire logic        i_out_busy,
    input  wire rpt_pkg::t_sts i_sts,
    output logic             o_idle,
    output rpt_pkg::t_ctl    o_ctl
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_HEADW = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_TEST  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_idle  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_fire) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.cmd == rpt_pkg::CMD_FREETO) begin
                    n_state = S_RD;
                end else if (i_sts.cmd == rpt_pkg::CMD_FREEFIRST) begin
                    if (i_sts.empty) begin
                        n_state = S_OUT;
                    end else begin
                        o_ctl.rd_head = 1'b1;
                        n_state       = S_HEADW;
                    end
                end else begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_HEADW: begin
                o_ctl.set_bound = 1'b1;
                n_state         = S_RD;
            end
            S_RD: begin
                // read at walk pointer issued here, tested next cycle
                if (i_sts.more) begin
                    n_state = S_TEST;
                end else begin
                    o_ctl.free_done = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_TEST: begin
                if (i_sts.le) begin
                    o_ctl.free_step = 1'b1;
                    n_state         = S_RD;
                end else begin
                    o_ctl.free_done = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* hdl/rpt_dp.sv */
// Datapath: tracker registers, window ring and result register.
`timescale 1ns / 1ps
`default_nettype none
module rpt_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rpt_pkg::t_ctl                i_ctl,
    input  wire logic [3:0]                   i_cmd,
    input  wire logic [rpt_pkg::IdxW-1:0]     i_index,
    input  wire logic [rpt_pkg::IdxW-1:0]     i_peer_last,
    input  wire logic                         i_cfg_we,
    input  wire logic [rpt_pkg::LimW-1:0]     i_cfg_wdata,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [207:0]                      o_out_data,
    output rpt_pkg::t_sts                     o_sts
);
    localparam int PW = rpt_pkg::PtrW;
    localparam int CW = rpt_pkg::CntW;
    localparam int XW = rpt_pkg::IdxW;

    logic [rpt_pkg::LimW-1:0] r_limit;
    logic [3:0]    r_cmd;
    logic [XW-1:0] r_idx, r_last, r_bound;
    logic [XW-1:0] r_match, r_next, r_pend;
    logic [1:0]    r_mode;
    logic          r_paused;
    logic [PW-1:0] r_head, r_ptr;
    logic [CW-1:0] r_count, r_n;
    logic          r_acc, r_ovf;
    logic          r_out_valid;
    logic [207:0]  r_out_data;

    logic [XW-1:0] ram_rdata;
    logic [CW-1:0] eff_lim;
    logic          full, ram_we;
    logic [PW-1:0] ram_raddr, waddr;

    always_comb begin
        if (r_limit == '0) begin
            eff_lim = CW'(1);
        end else if ({1'b0, r_limit} > (rpt_pkg::LimW + 1)'(rpt_pkg::WinDepth)) begin
            eff_lim = CW'(rpt_pkg::WinDepth);
        end else begin
            eff_lim = CW'(r_limit);
        end
    end
    assign full   = r_count >= eff_lim;
    assign waddr  = r_head + r_count[PW-1:0];
    assign ram_we = i_ctl.exec && (r_cmd == rpt_pkg::CMD_ADD) && !full;
    assign ram_raddr = i_ctl.rd_head ? r_head : r_ptr;

    rpt_ram #(.WIDTH(XW), .DEPTH(rpt_pkg::WinDepth)) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(r_idx),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_sts.cmd   = r_cmd;
    assign o_sts.empty = r_count == '0;
    assign o_sts.more  = r_n < r_count;
    assign o_sts.le    = ram_rdata <= r_bound;

    logic [XW-1:0] m1, p1, i1, l1, v;
    assign m1 = r_match + 1'b1;
    assign p1 = r_pend + 1'b1;
    assign i1 = r_idx + 1'b1;
    assign l1 = r_last + 1'b1;
    always_comb begin
        v = (r_idx < l1) ? r_idx : l1;
        if (v == '0) begin
            v = XW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_idx   <= i_index;
            r_last  <= i_peer_last;
            r_bound <= i_index;
            r_ptr   <= r_head;
            r_n     <= '0;
        end
        if (i_ctl.set_bound) begin
            r_bound <= ram_rdata;
        end
        if (i_ctl.free_step) begin
            r_ptr <= r_ptr + 1'b1;
            r_n   <= r_n + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= rpt_pkg::LimW'(rpt_pkg::WinDepth);
            r_match  <= '0;
            r_next   <= '0;
            r_pend   <= '0;
            r_mode   <= rpt_pkg::MODE_PROBE;
            r_paused <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_acc    <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_ctl.load) begin
                r_acc <= 1'b0;
                r_ovf <= 1'b0;
            end
            if (i_ctl.free_done) begin
                r_count <= r_count - r_n;
                r_head  <= (r_count == r_n) ? '0 : r_ptr;
            end
            if (i_ctl.exec) begin
                case (r_cmd)
                    rpt_pkg::CMD_INIT, rpt_pkg::CMD_PROBE,
                    rpt_pkg::CMD_REPLICATE, rpt_pkg::CMD_SNAPSHOT: begin
                        r_paused <= 1'b0;
                        r_pend   <= '0;
                        r_head   <= '0;
                        r_count  <= '0;
                        case (r_cmd)
                            rpt_pkg::CMD_INIT: begin
                                r_mode  <= rpt_pkg::MODE_PROBE;
                                r_match <= '0;
                                r_next  <= r_idx;
                            end
                            rpt_pkg::CMD_PROBE: begin
                                r_mode <= rpt_pkg::MODE_PROBE;
                                if (r_mode == rpt_pkg::MODE_SNAPSHOT && p1 > m1) begin
                                    r_next <= p1;
                                end else begin
                                    r_next <= m1;
                                end
                            end
                            rpt_pkg::CMD_REPLICATE: begin
                                r_mode <= rpt_pkg::MODE_REPLICATE;
                                r_next <= m1;
                            end
                            default: begin
                                r_mode <= rpt_pkg::MODE_SNAPSHOT;
                                r_pend <= r_idx;
                            end
                        endcase
                    end
                    rpt_pkg::CMD_UPDATE: begin
                        if (r_match < r_idx) begin
                            r_match  <= r_idx;
                            r_acc    <= 1'b1;
                            r_paused <= 1'b0;
                        end
                        if (r_next < i1) begin
                            r_next <= i1;
                        end
                    end
                    rpt_pkg::CMD_OPTIM:    r_next   <= i1;
                    rpt_pkg::CMD_SNAPFAIL: r_pend   <= '0;
                    rpt_pkg::CMD_PAUSE:    r_paused <= 1'b1;
                    rpt_pkg::CMD_RESUME:   r_paused <= 1'b0;
                    rpt_pkg::CMD_DECR: begin
                        if (r_mode == rpt_pkg::MODE_REPLICATE) begin
                            if (r_idx > r_match) begin
                                r_next <= m1;
                                r_acc  <= 1'b1;
                            end
                        end else if (r_next - 1'b1 == r_idx) begin
                            r_next   <= v;
                            r_paused <= 1'b0;
                            r_acc    <= 1'b1;
                        end
                    end
                    rpt_pkg::CMD_ADD: begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    logic paused_now;
    always_comb begin
        case (r_mode)
            rpt_pkg::MODE_PROBE:     paused_now = r_paused;
            rpt_pkg::MODE_REPLICATE: paused_now = full;
            default:                 paused_now = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctl.out_load) begin
            r_out_data <= {1'b0, r_ovf, r_count, r_pend, r_next, r_match, r_mode,
                           (r_mode == rpt_pkg::MODE_SNAPSHOT) && (r_match >= r_pend),
                           paused_now, r_acc};
        end
    end
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the replication progress tracker: predicted status per command transfer.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    // lowest field last: packed structs fill from the top bit down
    typedef struct packed {
        logic        overflow_error;
        logic [8:0]  window_fill;
        logic [63:0] pending_out;
        logic [63:0] next_out;
        logic [63:0] match_out;
        logic [1:0]  mode_now;
        logic        snapshot_abort;
        logic        paused_now;
        logic        accepted;
    } t_status;

    class progress_board;
        logic [63:0] match_q, next_q, pend_q;
        logic [1:0]  mode_q;
        logic        paused_q;
        logic [63:0] ring [rpt_pkg::WinDepth];
        int          head, count, limit;
        t_status     pending_status [$];
        int          errors;

        function void clear_state();
            match_q = '0; next_q = '0; pend_q = '0; mode_q = rpt_pkg::MODE_PROBE;
            paused_q = 1'b0; head = 0; count = 0; limit = rpt_pkg::WinDepth; errors = 0;
        endfunction

        function void set_limit(logic [8:0] v);
            limit = (v == 0) ? 1 : ((v > rpt_pkg::WinDepth) ? rpt_pkg::WinDepth : v);
        endfunction

        function void enter_mode(logic [1:0] m);
            paused_q = 1'b0; pend_q = '0; mode_q = m; head = 0; count = 0;
        endfunction

        function void free_upto(logic [63:0] bound);
            int pos, n;
            pos = head;
            n = 0;
            while (n < count && ring[pos % rpt_pkg::WinDepth] <= bound) begin
                n++;
                pos = (pos + 1) % rpt_pkg::WinDepth;
            end
            count -= n;
            head = (count == 0) ? 0 : pos;
        endfunction

        function void note_command(logic [3:0] cmd, logic [63:0] idx, logic [63:0] last);
            t_status     s;
            logic [1:0]  old_mode;
            logic [63:0] a, b, v;
            s = '0;
            case (cmd)
                rpt_pkg::CMD_INIT: begin
                    enter_mode(rpt_pkg::MODE_PROBE); match_q = '0; next_q = idx;
                end
                rpt_pkg::CMD_PROBE: begin
                    old_mode = mode_q; b = pend_q + 64'd1; a = match_q + 64'd1;
                    enter_mode(rpt_pkg::MODE_PROBE);
                    next_q = (old_mode == rpt_pkg::MODE_SNAPSHOT && b > a) ? b : a;
                end
                rpt_pkg::CMD_REPLICATE: begin
                    enter_mode(rpt_pkg::MODE_REPLICATE); next_q = match_q + 64'd1;
                end
                rpt_pkg::CMD_SNAPSHOT: begin
                    enter_mode(rpt_pkg::MODE_SNAPSHOT); pend_q = idx;
                end
                rpt_pkg::CMD_UPDATE: begin
                    if (match_q < idx) begin
                        match_q = idx; s.accepted = 1'b1; paused_q = 1'b0;
                    end
                    if (next_q < idx + 64'd1) next_q = idx + 64'd1;
                end
                rpt_pkg::CMD_OPTIM: next_q = idx + 64'd1;
                rpt_pkg::CMD_SNAPFAIL: pend_q = '0;
                rpt_pkg::CMD_DECR: begin
                    if (mode_q == rpt_pkg::MODE_REPLICATE) begin
                        if (idx > match_q) begin
                            next_q = match_q + 64'd1; s.accepted = 1'b1;
                        end
                    end else if (next_q - 64'd1 == idx) begin
                        a = last + 64'd1;
                        v = (idx < a) ? idx : a;
                        if (v == 0) v = 64'd1;
                        next_q = v; paused_q = 1'b0; s.accepted = 1'b1;
                    end
                end
                rpt_pkg::CMD_PAUSE: paused_q = 1'b1;
                rpt_pkg::CMD_RESUME: paused_q = 1'b0;
                rpt_pkg::CMD_ADD: begin
                    if (count >= limit) s.overflow_error = 1'b1;
                    else begin
                        ring[(head + count) % rpt_pkg::WinDepth] = idx; count++;
                    end
                end
                rpt_pkg::CMD_FREETO: free_upto(idx);
                rpt_pkg::CMD_FREEFIRST:
                    if (count != 0) free_upto(ring[head % rpt_pkg::WinDepth]);
                default: ;
            endcase
            if (mode_q == rpt_pkg::MODE_PROBE) s.paused_now = paused_q;
            else if (mode_q == rpt_pkg::MODE_REPLICATE) s.paused_now = (count >= limit);
            else s.paused_now = 1'b1;
            s.snapshot_abort = (mode_q == rpt_pkg::MODE_SNAPSHOT) && (match_q >= pend_q);
            s.mode_now = mode_q;
            s.match_out = match_q;
            s.next_out = next_q;
            s.pending_out = pend_q;
            s.window_fill = count[8:0];
            pending_status.push_back(s);
        endfunction

        function void check_status(t_status got);
            t_status e;
            if (pending_status.size() == 0) begin
                $error("result with no prediction waiting");
                errors++;
                return;
            end
            e = pending_status.pop_front();
            if (got.accepted !== e.accepted) begin
                $error("accepted exp %0d got %0d", e.accepted, got.accepted); errors++;
            end
            if (got.paused_now !== e.paused_now) begin
                $error("paused_now exp %0d got %0d", e.paused_now, got.paused_now); errors++;
            end
            if (got.snapshot_abort !== e.snapshot_abort) begin
                $error("snapshot_abort exp %0d got %0d", e.snapshot_abort,
                       got.snapshot_abort); errors++;
            end
            if (got.mode_now !== e.mode_now) begin
                $error("mode_now exp %0d got %0d", e.mode_now, got.mode_now); errors++;
            end
            if (got.match_out !== e.match_out) begin
                $error("match_out exp %0h got %0h", e.match_out, got.match_out); errors++;
            end
            if (got.next_out !== e.next_out) begin
                $error("next_out exp %0h got %0h", e.next_out, got.next_out); errors++;
            end
            if (got.pending_out !== e.pending_out) begin
                $error("pending_out exp %0h got %0h", e.pending_out, got.pending_out);
                errors++;
            end
            if (got.window_fill !== e.window_fill) begin
                $error("window_fill exp %0d got %0d", e.window_fill, got.window_fill);
                errors++;
            end
            if (got.overflow_error !== e.overflow_error) begin
                $error("overflow_error exp %0d got %0d", e.overflow_error,
                       got.overflow_error); errors++;
            end
        endfunction
    endclass

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, m_axis_tready, i_cfg_we;
    logic         s_axis_tready, m_axis_tvalid;
    logic [135:0] s_axis_tdata;
    logic [207:0] m_axis_tdata;
    logic [8:0]   i_cfg_wdata;

    progress_board board;
    int            idle_cycles;
    bit            stall_on;
    int            stall_mode;
    logic [63:0]   last_val;

    replication_progress_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    initial begin
        board = new();
        board.clear_state();
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        stall_on = 1'b0; stall_mode = 0;
    end

    // receiver stall pattern: phases of no stall, occasional random stalls, and frequent random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_status(m_axis_tdata[206:0]);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= 20000) begin
            $display("== FAIL ==");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end

    task automatic send_cmd(logic [3:0] cmd, logic [63:0] idx, logic [63:0] last);
        s_axis_tdata <= {4'd0, last, idx, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_command(cmd, idx, last);
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_config(logic [8:0] lim);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_limit(lim);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // index values clustered near current state so comparisons go both ways
    function automatic logic [63:0] near_val(logic [63:0] base);
        case ($urandom_range(0, 5))
            0: return rand64();
            1: return base;
            2: return base + 64'd1;
            3: return base - 64'd1;
            default: return base + $urandom_range(0, 8);
        endcase
    endfunction

    task automatic random_phase(int n);
        int          burst;
        logic [3:0]  cmd;
        logic [63:0] idx, last;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            cmd = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0) cmd = rpt_pkg::CMD_ADD;
            case (cmd)
                rpt_pkg::CMD_ADD: begin
                    last_val = last_val + $urandom_range(0, 3);
                    idx = ($urandom_range(0, 19) == 0) ? rand64() : last_val;
                end
                rpt_pkg::CMD_FREETO: idx = last_val - $urandom_range(0, 6);
                rpt_pkg::CMD_DECR: idx = near_val(board.next_q - 64'd1);
                rpt_pkg::CMD_INIT, rpt_pkg::CMD_SNAPSHOT:
                    idx = ($urandom_range(0, 3) == 0) ? rand64()
                          : board.match_q + $urandom_range(0, 20);
                default: idx = near_val(board.match_q);
            endcase
            last = ($urandom_range(0, 3) == 0) ? rand64() : idx - $urandom_range(0, 4);
            send_cmd(cmd, idx, last);
            burst--;
            if (burst == 0) begin
                gap($urandom_range(0, 1) ? $urandom_range(1, 20) : 0);
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    initial begin
        logic [63:0] top;
        top = '1;
        last_val = 64'd100;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every command, wrap cases, overflow at limit 1
        drain_and_config(9'd1);
        send_cmd(rpt_pkg::CMD_PAUSE, 0, 0);
        send_cmd(rpt_pkg::CMD_RESUME, 0, 0);
        send_cmd(rpt_pkg::CMD_INIT, 64'd10, 0);
        send_cmd(rpt_pkg::CMD_UPDATE, top, 0);
        send_cmd(rpt_pkg::CMD_OPTIM, top, 0);
        send_cmd(rpt_pkg::CMD_DECR, top, top);
        send_cmd(rpt_pkg::CMD_DECR, 64'd5, 0);
        send_cmd(rpt_pkg::CMD_INIT, 64'd1, 0);
        send_cmd(rpt_pkg::CMD_DECR, 64'd0, top);
        send_cmd(rpt_pkg::CMD_REPLICATE, 0, 0);
        send_cmd(rpt_pkg::CMD_ADD, 64'd7, 0);
        send_cmd(rpt_pkg::CMD_ADD, 64'd8, 0);
        send_cmd(rpt_pkg::CMD_DECR, 64'd0, 0);
        send_cmd(rpt_pkg::CMD_DECR, 64'd3, 0);
        send_cmd(rpt_pkg::CMD_FREEFIRST, 0, 0);
        send_cmd(rpt_pkg::CMD_FREEFIRST, 0, 0);
        send_cmd(rpt_pkg::CMD_FREETO, top, 0);
        send_cmd(rpt_pkg::CMD_SNAPSHOT, 64'd50, 0);
        send_cmd(rpt_pkg::CMD_UPDATE, 64'd50, 0);
        send_cmd(rpt_pkg::CMD_SNAPFAIL, 0, 0);
        send_cmd(rpt_pkg::CMD_SNAPSHOT, 64'd80, 0);
        send_cmd(rpt_pkg::CMD_PROBE, 0, 0);
        send_cmd(4'd13, top, top);
        send_cmd(4'd15, 0, 0);

        drain_and_config(9'd0);
        stall_mode = 1;
        random_phase(80);
        drain_and_config(9'd256);
        send_cmd(rpt_pkg::CMD_REPLICATE, 0, 0);
        for (int k = 0; k < 258; k++) send_cmd(rpt_pkg::CMD_ADD, last_val + k, 0);
        send_cmd(rpt_pkg::CMD_FREETO, last_val + 200, 0);
        send_cmd(rpt_pkg::CMD_FREETO, top, 0);
        stall_mode = 2;
        random_phase(100);
        drain_and_config(9'd511);
        stall_mode = 0;
        random_phase(80);
        drain_and_config(9'd4);
        stall_mode = 1;
        random_phase(100);
        drain_and_config(9'($urandom_range(1, 300)));
        stall_mode = 2;
        random_phase(100);

        s_axis_tvalid <= 1'b0;
        while (board.pending_status.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending_status.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
